/* design/brdf_lut_texel_integrator_assert.svh */
// Assertion macros for the BRDF LUT texel integrator.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BRDF_LUT_TEXEL_INTEGRATOR_ASSERT_SVH
`define BRDF_LUT_TEXEL_INTEGRATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BLTI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BLTI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/blti_pkg.sv */
// Shared constants, types and constant functions of the BRDF LUT texel integrator.
// No dependencies. SAMPLES must be a power of two; outputs assume 16 fraction bits.
package blti_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SAMPLES   = 256;
	localparam int SMP_W     = $clog2(SAMPLES);
	localparam int Q_W       = FRAC_BITS + 1;          // 0..ONE
	localparam int P_W       = 2 * Q_W;                // product of two Q values
	localparam int COL_W     = 12;
	localparam int SIZE_W    = 13;
	localparam int OUT_W     = 18;
	localparam int G_W       = FRAC_BITS + 9;          // G capped at 256.0
	localparam int T_W       = FRAC_BITS + 11;         // T capped at 1024.0
	localparam int GV_W      = G_W + FRAC_BITS;        // G * VdotH
	localparam int PR_W      = Q_W + T_W;              // (1-Fc) * T
	localparam int C_W       = PR_W - FRAC_BITS;       // one sample contribution
	localparam int ACC_W     = C_W + SMP_W;

	localparam logic [Q_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam longint EPS_RAW = ((longint'(1) << FRAC_BITS) + 50000) / 100000;
	localparam logic [Q_W-1:0] EPS = (EPS_RAW == 0) ? Q_W'(1) : Q_W'(EPS_RAW);
	localparam logic [G_W-1:0] G_MAX = {1'b1, {(G_W-1){1'b0}}};
	localparam logic [T_W-1:0] T_MAX = {1'b1, {(T_W-1){1'b0}}};
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [0:0] {
		REG_LUT_WIDTH  = 1'b0,
		REG_LUT_HEIGHT = 1'b1
	} reg_idx_t;

	// per-texel values handed from the front end to the sample issuer
	typedef struct packed {
		logic [Q_W-1:0] nv;
		logic [Q_W-1:0] vx;
		logic [Q_W-1:0] a2;
	} texel_t;

	typedef struct packed {
		logic busy;
		logic issue;
	} smp_stat_t;

	typedef struct packed {
		logic           last;
		logic [C_W-1:0] pa;
		logic [C_W-1:0] pb;
	} samp_res_t;

	// radical inverse: top FRAC_BITS bits of the 32-bit bit reversal
	function automatic logic [FRAC_BITS-1:0] xi_of(input logic [SMP_W-1:0] i);
		logic [FRAC_BITS-1:0] r;
		r = '0;
		for (int k = 0; k < SMP_W; k++)
			r[FRAC_BITS-1-k] = i[k];
		return r;
	endfunction

	function automatic longint unsigned mul30(input longint unsigned a,
			input longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic longint unsigned sin_q30(input longint unsigned t);
		longint unsigned t2;
		longint unsigned v;
		t2 = mul30(t, t);
		v = Q30_ONE - t2 / 110;
		v = Q30_ONE - mul30(t2, v) / 72;
		v = Q30_ONE - mul30(t2, v) / 42;
		v = Q30_ONE - mul30(t2, v) / 20;
		v = Q30_ONE - mul30(t2, v) / 6;
		return mul30(t, v);
	endfunction

	function automatic longint q30_to_q(input longint unsigned v);
		longint unsigned r;
		r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		if (r > (64'd1 << FRAC_BITS))
			r = 64'd1 << FRAC_BITS;
		return longint'(r);
	endfunction

	// cosine of the sample azimuth, elaboration-time table entry
	function automatic logic signed [Q_W:0] phase_cos(input int i);
		longint unsigned k;
		longint unsigned quad;
		longint unsigned t;
		longint sv;
		longint cv;
		longint c;
		k = longint'(i) * 4;
		quad = (k / SAMPLES) & 3;
		t = (k % SAMPLES) * HALF_PI_Q30 / SAMPLES;
		sv = q30_to_q(sin_q30(t));
		cv = q30_to_q(sin_q30(HALF_PI_Q30 - t));
		case (quad)
			0:       c = cv;
			1:       c = -sv;
			2:       c = -cv;
			default: c = sv;
		endcase
		return (Q_W+1)'(c);
	endfunction

endpackage

/* design/brdf_lut_texel_integrator.sv */
// BRDF LUT texel integrator: two size registers, one texel in, one (A, B) pair out.
// Depends on blti_pkg, blti_texel, blti_sample, blti_accum and the assertion header.
//
// Usage
//   s_axis: one transaction per texel, tdata = {row_index, col_index}.
//   m_axis: one transaction per texel, in order, tdata = {bias_term, scale_term}.
//   cfg:    register writes (index 0 lut_width, 1 lut_height); cfg_ready is
//           always high. Write only while no texel is in flight.
// Throughput: one importance sample per cycle through the sample pipeline
//   while no stall freezes it; the issuer is the limit. A new texel is taken
//   while the previous one is still draining, so texels follow with no gap.
// Path: the texel front end (29-stage dividers, a 17-stage root), the issue
//   of the texel's samples, then the sample pipeline drain (three long
//   dividers and two roots, one bit per stage).
// Reset: arst_n clears all valid bits, the sample issuer and the sums; sizes
//   return to 512 x 512. No clearing pass; the block is ready right away.
// Stall: a held result waits in the output register; the pipeline keeps
//   running and freezes only when a texel's last sample would overwrite it.
// Input ready is low while the front end holds a texel the issuer has not taken.
module brdf_lut_texel_integrator (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: [11:0] col_index, [23:12] row_index
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	// tdata: [17:0] scale_term, [35:18] bias_term, [39:36] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	`include "brdf_lut_texel_integrator_assert.svh"

	logic [blti_pkg::SIZE_W-1:0] lut_w_q, lut_h_q;

	logic                   fo_vld, fo_take, adv, res_vld;
	blti_pkg::texel_t       fo_texel;
	blti_pkg::smp_stat_t    st;
	blti_pkg::samp_res_t    res;
	logic [blti_pkg::OUT_W-1:0] scale, bias;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lut_w_q <= blti_pkg::SIZE_W'(512);
			lut_h_q <= blti_pkg::SIZE_W'(512);
		end else if (cfg_valid) begin
			unique case (blti_pkg::reg_idx_t'(cfg_index))
				blti_pkg::REG_LUT_WIDTH:  lut_w_q <= cfg_data;
				blti_pkg::REG_LUT_HEIGHT: lut_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-texel front end
	blti_texel u_texel (
		.clk, .arst_n,
		.in_vld(s_axis_tvalid),
		.in_rdy(s_axis_tready),
		.col(s_axis_tdata[11:0]),
		.row(s_axis_tdata[23:12]),
		.lut_w(lut_w_q),
		.lut_h(lut_h_q),
		.out_vld(fo_vld),
		.out_texel(fo_texel),
		.take(fo_take)
	);

	// sample issuer and sample pipeline
	blti_sample u_sample (
		.clk, .arst_n,
		.adv(adv),
		.fo_vld(fo_vld),
		.fo(fo_texel),
		.take(fo_take),
		.stat(st),
		.res_vld(res_vld),
		.res(res)
	);

	// sums and output register
	blti_accum u_accum (
		.clk, .arst_n,
		.in_vld(res_vld),
		.in_res(res),
		.adv(adv),
		.out_vld(m_axis_tvalid),
		.out_rdy(m_axis_tready),
		.scale(scale),
		.bias(bias)
	);

	assign m_axis_tdata = {4'b0000, bias, scale};

	`BLTI_ASSERT_IMP(a_take_needs_texel, fo_take, fo_vld,
		"issuer took a texel the front end did not hold")
	`BLTI_ASSERT_NXT(a_take_starts_run, fo_take, st.busy,
		"issuer not busy after taking a texel")
	`BLTI_ASSERT_IMP(a_stall_cause, !adv, m_axis_tvalid && !m_axis_tready,
		"sample pipeline frozen without a blocked result")

endmodule

/* design/blti_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on nothing; used by the texel front end and the sample pipeline.
module blti_div_pipe #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 17,
	parameter int PAY_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [PAY_W-1:0] in_pay,
	output logic             out_vld,
	output logic [NUM_W-1:0] out_quo,
	output logic [PAY_W-1:0] out_pay
);

	logic             vld_s [1:NUM_W];
	logic [DEN_W-1:0] rem_s [1:NUM_W];
	logic [NUM_W-1:0] nq_s  [1:NUM_W];
	logic [DEN_W-1:0] den_s [1:NUM_W];
	logic [PAY_W-1:0] pay_s [1:NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic             vld_in;
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] nq_in;
		logic [DEN_W-1:0] den_in;
		logic [PAY_W-1:0] pay_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_in = in_vld;
			assign rem_in = '0;
			assign nq_in  = in_num;
			assign den_in = in_den;
			assign pay_in = in_pay;
		end else begin : g_next
			assign vld_in = vld_s[k];
			assign rem_in = rem_s[k];
			assign nq_in  = nq_s[k];
			assign den_in = den_s[k];
			assign pay_in = pay_s[k];
		end

		assign trial = {rem_in, nq_in[NUM_W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				nq_s[k+1]  <= {nq_in[NUM_W-2:0], ge};
				den_s[k+1] <= den_in;
				pay_s[k+1] <= pay_in;
			end
		end
	end

	assign out_vld = vld_s[NUM_W];
	assign out_quo = nq_s[NUM_W];
	assign out_pay = pay_s[NUM_W];

endmodule

/* design/blti_sqrt_pipe.sv */
// Pipelined integer square root, one root bit per stage, with a side payload.
// Depends on nothing; floor(sqrt(in_val)).
module blti_sqrt_pipe #(
	parameter int R_W   = 17,
	parameter int PAY_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [2*R_W-1:0]   in_val,
	input  logic [PAY_W-1:0]   in_pay,
	output logic               out_vld,
	output logic [R_W-1:0]     out_root,
	output logic [PAY_W-1:0]   out_pay
);

	logic               vld_s  [1:R_W];
	logic [R_W+1:0]     rem_s  [1:R_W];
	logic [R_W-1:0]     root_s [1:R_W];
	logic [2*R_W-1:0]   val_s  [1:R_W];
	logic [PAY_W-1:0]   pay_s  [1:R_W];

	for (genvar k = 0; k < R_W; k++) begin : g_stage
		logic             vld_in;
		logic [R_W+1:0]   rem_in;
		logic [R_W-1:0]   root_in;
		logic [2*R_W-1:0] val_in;
		logic [PAY_W-1:0] pay_in;
		logic [R_W+3:0]   cur;
		logic [R_W+3:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign root_in = '0;
			assign val_in  = in_val;
			assign pay_in  = in_pay;
		end else begin : g_next
			assign vld_in  = vld_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
			assign val_in  = val_s[k];
			assign pay_in  = pay_s[k];
		end

		assign cur   = {rem_in, val_in[2*R_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (R_W+2)'(cur - trial) : cur[R_W+1:0];
				root_s[k+1] <= {root_in[R_W-2:0], ge};
				val_s[k+1]  <= {val_in[2*R_W-3:0], 2'b00};
				pay_s[k+1]  <= pay_in;
			end
		end
	end

	assign out_vld  = vld_s[R_W];
	assign out_root = root_s[R_W];
	assign out_pay  = pay_s[R_W];

endmodule

/* design/blti_texel.sv */
// Texel front end: NdotV, roughness, alpha^2 and the view tangent term per texel.
// Depends on blti_pkg, blti_div_pipe, blti_sqrt_pipe.
module blti_texel (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_vld,
	output logic                            in_rdy,
	input  logic [blti_pkg::COL_W-1:0]      col,
	input  logic [blti_pkg::COL_W-1:0]      row,
	input  logic [blti_pkg::SIZE_W-1:0]     lut_w,
	input  logic [blti_pkg::SIZE_W-1:0]     lut_h,
	output logic                            out_vld,
	output blti_pkg::texel_t                out_texel,
	input  logic                            take
);

	localparam int Q   = blti_pkg::FRAC_BITS;
	localparam int QW  = blti_pkg::Q_W;
	localparam int PW  = blti_pkg::P_W;
	localparam int NW  = blti_pkg::COL_W + 1 + Q;
	localparam int DW  = blti_pkg::SIZE_W + 1;

	logic                  fen;
	logic [blti_pkg::SIZE_W-1:0] n_w, n_h;
	logic                  dv_vld;
	logic [NW-1:0]         q_nv, q_ro;
	logic [QW-1:0]         nv, rough;

	logic                  vld_s1;
	logic [PW-1:0]         nn_s1, rr_s1;
	logic [QW-1:0]         nv_s1;
	logic                  vld_s2;
	logic [PW-1:0]         a2p_s2;
	logic [PW-1:0]         arg_s2;
	logic [QW-1:0]         nv_s2;

	logic                  sq_vld;
	logic [QW-1:0]         sq_root;
	logic [2*QW-1:0]       sq_pay;

	logic                  fo_vld_q;
	blti_pkg::texel_t      fo_q;

	assign fen    = !fo_vld_q || take;
	assign in_rdy = fen;

	// a zero size reads as one
	assign n_w = (lut_w == '0) ? blti_pkg::SIZE_W'(1) : lut_w;
	assign n_h = (lut_h == '0) ? blti_pkg::SIZE_W'(1) : lut_h;

	blti_div_pipe #(.NUM_W(NW), .DEN_W(DW), .PAY_W(1)) u_div_nv (
		.clk, .arst_n, .en(fen),
		.in_vld(in_vld),
		.in_num({col, 1'b1, {Q{1'b0}}}),
		.in_den({n_w, 1'b0}),
		.in_pay(1'b0),
		.out_vld(dv_vld), .out_quo(q_nv), .out_pay()
	);

	blti_div_pipe #(.NUM_W(NW), .DEN_W(DW), .PAY_W(1)) u_div_ro (
		.clk, .arst_n, .en(fen),
		.in_vld(in_vld),
		.in_num({row, 1'b1, {Q{1'b0}}}),
		.in_den({n_h, 1'b0}),
		.in_pay(1'b0),
		.out_vld(), .out_quo(q_ro), .out_pay()
	);

	assign nv    = (q_nv > NW'(blti_pkg::ONE)) ? blti_pkg::ONE : q_nv[QW-1:0];
	assign rough = (q_ro > NW'(blti_pkg::ONE)) ? blti_pkg::ONE : q_ro[QW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (fen) begin
			vld_s1 <= dv_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			nn_s1  <= PW'(nv) * PW'(nv);
			rr_s1  <= PW'(rough) * PW'(rough);
			nv_s1  <= nv;
			a2p_s2 <= PW'(rr_s1[Q +: QW]) * PW'(rr_s1[Q +: QW]);
			arg_s2 <= {1'b0, QW'(blti_pkg::ONE - nn_s1[Q +: QW]), {Q{1'b0}}};
			nv_s2  <= nv_s1;
		end
	end

	blti_sqrt_pipe #(.R_W(QW), .PAY_W(2*QW)) u_sqrt_vx (
		.clk, .arst_n, .en(fen),
		.in_vld(vld_s2),
		.in_val(arg_s2),
		.in_pay({nv_s2, a2p_s2[Q +: QW]}),
		.out_vld(sq_vld), .out_root(sq_root), .out_pay(sq_pay)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fo_vld_q <= 1'b0;
		else if (fen)
			fo_vld_q <= sq_vld;
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			fo_q.nv <= sq_pay[2*QW-1:QW];
			fo_q.a2 <= sq_pay[QW-1:0];
			fo_q.vx <= sq_root;
		end
	end

	assign out_vld   = fo_vld_q;
	assign out_texel = fo_q;

endmodule

/* design/blti_sample.sv */
// Sample issuer and per-sample pipeline: half vector, G, Fresnel, A and B terms.
// Depends on blti_pkg, blti_div_pipe, blti_sqrt_pipe.
module blti_sample (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   fo_vld,
	input  blti_pkg::texel_t       fo,
	output logic                   take,
	output blti_pkg::smp_stat_t    stat,
	output logic                   res_vld,
	output blti_pkg::samp_res_t    res
);

	localparam int Q   = blti_pkg::FRAC_BITS;
	localparam int QW  = blti_pkg::Q_W;
	localparam int PW  = blti_pkg::P_W;
	localparam int SW  = blti_pkg::SMP_W;
	localparam int GW  = blti_pkg::G_W;
	localparam int TW  = blti_pkg::T_W;
	localparam int VW  = blti_pkg::GV_W;
	localparam int RW  = blti_pkg::PR_W;
	localparam int CW  = blti_pkg::C_W;
	localparam int D1W = 2 * Q + 1;
	localparam int HW  = 2 * QW + 2;
	localparam int DTW = 2 * QW + 3;

	typedef struct packed {
		logic                 last;
		logic signed [QW:0]   cp;
		logic [QW-1:0]        nv;
		logic [QW-1:0]        vx;
	} p1_t;

	typedef struct packed {
		logic                 last;
		logic signed [QW:0]   cp;
		logic [QW-1:0]        nv;
		logic [QW-1:0]        vx;
		logic [QW-1:0]        ct;
		logic [QW-1:0]        cnd;
	} p2_t;

	typedef struct packed {
		logic                 last;
		logic                 zero;
		logic [QW-1:0]        vh;
		logic [QW-1:0]        om;
		logic [QW-1:0]        cnd;
	} pg_t;

	typedef struct packed {
		logic                 last;
		logic                 zero;
		logic [QW-1:0]        fc;
	} pt_t;

	logic signed [QW:0] cos_tab [blti_pkg::SAMPLES];

	for (genvar gi = 0; gi < blti_pkg::SAMPLES; gi++) begin : g_cos
		assign cos_tab[gi] = blti_pkg::phase_cos(gi);
	end

	// issuer
	logic                busy_q;
	logic [SW-1:0]       idx_q;
	blti_pkg::texel_t    cur_q;
	logic                last_i, issue;

	assign last_i = idx_q == SW'(blti_pkg::SAMPLES - 1);
	assign issue  = busy_q && adv;
	assign take   = fo_vld && (!busy_q || (issue && last_i));
	assign stat   = '{busy: busy_q, issue: issue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (issue) begin
			if (last_i)
				busy_q <= 1'b0;
			idx_q <= idx_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			cur_q <= fo;
	end

	// stage 1: sample constants
	logic                vld_s1, last_s1;
	logic [Q-1:0]        xi_s1;
	logic signed [QW:0]  cp_s1;
	logic [QW-1:0]       nv_s1, vx_s1, a2_s1;

	// stage 2: ratio numerator and denominator product
	logic                vld_s2, last_s2;
	logic signed [QW:0]  cp_s2;
	logic [QW-1:0]       nv_s2, vx_s2;
	logic [D1W-1:0]      num_s2;
	logic [PW-1:0]       prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= last_i;
			xi_s1   <= blti_pkg::xi_of(idx_q);
			cp_s1   <= cos_tab[idx_q];
			nv_s1   <= cur_q.nv;
			vx_s1   <= cur_q.vx;
			a2_s1   <= cur_q.a2;
			last_s2 <= last_s1;
			cp_s2   <= cp_s1;
			nv_s2   <= nv_s1;
			vx_s2   <= vx_s1;
			num_s2  <= {QW'(blti_pkg::ONE - QW'(xi_s1)), {Q{1'b0}}};
			prod_s2 <= PW'(QW'(blti_pkg::ONE - a2_s1)) * PW'(xi_s1);
		end
	end

	// ratio = (1 - xi) / (1 - (1 - a2) xi)
	logic           d1_vld;
	logic [D1W-1:0] d1_quo;
	logic [$bits(p1_t)-1:0] d1_pay;
	logic [QW-1:0]  ratio;

	blti_div_pipe #(.NUM_W(D1W), .DEN_W(QW), .PAY_W($bits(p1_t))) u_div_ratio (
		.clk, .arst_n, .en(adv),
		.in_vld(vld_s2),
		.in_num(num_s2),
		.in_den(QW'(blti_pkg::ONE - prod_s2[Q +: QW])),
		.in_pay(p1_t'{last: last_s2, cp: cp_s2, nv: nv_s2, vx: vx_s2}),
		.out_vld(d1_vld), .out_quo(d1_quo), .out_pay(d1_pay)
	);

	assign ratio = (d1_quo > D1W'(blti_pkg::ONE)) ? blti_pkg::ONE : d1_quo[QW-1:0];

	// cos(theta) = sqrt(ratio)
	logic           c_vld;
	logic [QW-1:0]  c_root;
	logic [$bits(p1_t)-1:0] c_pay;
	p1_t            c_p;

	blti_sqrt_pipe #(.R_W(QW), .PAY_W($bits(p1_t))) u_sqrt_ct (
		.clk, .arst_n, .en(adv),
		.in_vld(d1_vld),
		.in_val({1'b0, ratio, {Q{1'b0}}}),
		.in_pay(d1_pay),
		.out_vld(c_vld), .out_root(c_root), .out_pay(c_pay)
	);

	assign c_p = p1_t'(c_pay);

	// stage 3: ct^2 and ct*nv
	logic           vld_s3;
	p1_t            p_s3;
	logic [QW-1:0]  ct_s3;
	logic [PW-1:0]  cc_s3, cn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (adv)
			vld_s3 <= c_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3  <= c_p;
			ct_s3 <= c_root;
			cc_s3 <= PW'(c_root) * PW'(c_root);
			cn_s3 <= PW'(c_root) * PW'(c_p.nv);
		end
	end

	// sin(theta)
	logic           s_vld;
	logic [QW-1:0]  s_root;
	logic [$bits(p2_t)-1:0] s_pay;
	p2_t            s_p;

	blti_sqrt_pipe #(.R_W(QW), .PAY_W($bits(p2_t))) u_sqrt_st (
		.clk, .arst_n, .en(adv),
		.in_vld(vld_s3),
		.in_val({1'b0, QW'(blti_pkg::ONE - cc_s3[Q +: QW]), {Q{1'b0}}}),
		.in_pay(p2_t'{last: p_s3.last, cp: p_s3.cp, nv: p_s3.nv, vx: p_s3.vx,
			ct: ct_s3, cnd: QW'(cn_s3[Q +: QW] + blti_pkg::EPS)}),
		.out_vld(s_vld), .out_root(s_root), .out_pay(s_pay)
	);

	assign s_p = p2_t'(s_pay);

	// stage 4: cos(phi) * sin(theta)
	logic                 vld_s4;
	p2_t                  p_s4;
	logic signed [HW-1:0] hp_s4;

	// stage 5: vx*hx and nv*ct
	logic                 vld_s5;
	p2_t                  p_s5;
	logic signed [HW-1:0] vxhx_s5;
	logic [PW-1:0]        nvct_s5;
	logic signed [HW-1:0] hadj;
	logic signed [QW:0]   hx;

	// truncate toward zero, as a signed divide by ONE
	assign hadj = hp_s4 + (hp_s4[HW-1] ? HW'((1 << Q) - 1) : HW'(0));
	assign hx   = hadj[Q +: QW+1];

	// stage 6: VdotH
	logic                  vld_s6, zero_s6;
	p2_t                   p_s6;
	logic [QW-1:0]         vh_s6;
	logic signed [DTW-1:0] dot;
	logic [DTW-Q-1:0]      dsh;
	logic [QW-1:0]         vh;

	assign dot = DTW'(vxhx_s5) + $signed({3'b000, nvct_s5});
	assign dsh = dot[DTW-1:Q];
	always_comb begin
		if (dot <= 0)
			vh = '0;
		else if (dsh > (DTW-Q)'(blti_pkg::ONE))
			vh = blti_pkg::ONE;
		else
			vh = dsh[QW-1:0];
	end

	// stage 7: G numerator and denominator product, 1 - VdotH
	logic           vld_s7, zero_s7;
	p2_t            p_s7;
	logic [QW-1:0]  vh_s7, om_s7;
	logic [PW-1:0]  nvvh_s7, vhct_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= s_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4    <= s_p;
			hp_s4   <= HW'(s_p.cp) * $signed({1'b0, s_root});
			p_s5    <= p_s4;
			vxhx_s5 <= $signed({1'b0, p_s4.vx}) * hx;
			nvct_s5 <= PW'(p_s4.nv) * PW'(p_s4.ct);
			p_s6    <= p_s5;
			vh_s6   <= vh;
			zero_s6 <= vh == '0;
			p_s7    <= p_s6;
			vh_s7   <= vh_s6;
			zero_s7 <= zero_s6;
			om_s7   <= QW'(blti_pkg::ONE - vh_s6);
			nvvh_s7 <= PW'(p_s6.nv) * PW'(vh_s6);
			vhct_s7 <= PW'(vh_s6) * PW'(p_s6.ct);
		end
	end

	// G = nv*vh / (vh*ct + eps)
	logic           dg_vld;
	logic [D1W-1:0] dg_quo;
	logic [$bits(pg_t)-1:0] dg_pay;
	pg_t            dg_p;
	logic [GW-1:0]  g;

	blti_div_pipe #(.NUM_W(D1W), .DEN_W(QW), .PAY_W($bits(pg_t))) u_div_g (
		.clk, .arst_n, .en(adv),
		.in_vld(vld_s7),
		.in_num(nvvh_s7[D1W-1:0]),
		.in_den(QW'(vhct_s7[Q +: QW] + blti_pkg::EPS)),
		.in_pay(pg_t'{last: p_s7.last, zero: zero_s7, vh: vh_s7, om: om_s7,
			cnd: p_s7.cnd}),
		.out_vld(dg_vld), .out_quo(dg_quo), .out_pay(dg_pay)
	);

	assign dg_p = pg_t'(dg_pay);
	assign g = (dg_quo > D1W'(blti_pkg::G_MAX)) ? blti_pkg::G_MAX : dg_quo[GW-1:0];

	// stages 8..10: G*vh and Fc = (1 - vh)^5
	logic           vld_s8, vld_s9, vld_s10;
	pg_t            p_s8, p_s9, p_s10;
	logic [VW-1:0]  gv_s8, gv_s9, gv_s10;
	logic [PW-1:0]  p2_s8, p4_s9, fc_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s8  <= dg_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s8   <= dg_p;
			gv_s8  <= VW'(g) * VW'(dg_p.vh);
			p2_s8  <= PW'(dg_p.om) * PW'(dg_p.om);
			p_s9   <= p_s8;
			gv_s9  <= gv_s8;
			p4_s9  <= PW'(p2_s8[Q +: QW]) * PW'(p2_s8[Q +: QW]);
			p_s10  <= p_s9;
			gv_s10 <= gv_s9;
			fc_s10 <= PW'(p4_s9[Q +: QW]) * PW'(p_s9.om);
		end
	end

	// T = G*vh / (ct*nv + eps)
	logic           dt_vld;
	logic [VW-1:0]  dt_quo;
	logic [$bits(pt_t)-1:0] dt_pay;
	pt_t            dt_p;
	logic [TW-1:0]  t;

	blti_div_pipe #(.NUM_W(VW), .DEN_W(QW), .PAY_W($bits(pt_t))) u_div_t (
		.clk, .arst_n, .en(adv),
		.in_vld(vld_s10),
		.in_num(gv_s10),
		.in_den(p_s10.cnd),
		.in_pay(pt_t'{last: p_s10.last, zero: p_s10.zero, fc: fc_s10[Q +: QW]}),
		.out_vld(dt_vld), .out_quo(dt_quo), .out_pay(dt_pay)
	);

	assign dt_p = pt_t'(dt_pay);
	assign t = (dt_quo > VW'(blti_pkg::T_MAX)) ? blti_pkg::T_MAX : dt_quo[TW-1:0];

	// stage 11: weighted terms, zeroed for samples without light
	logic           vld_s11;
	blti_pkg::samp_res_t r_s11;
	logic [RW-1:0]  pa, pb;

	assign pa = RW'(QW'(blti_pkg::ONE - dt_p.fc)) * RW'(t);
	assign pb = RW'(dt_p.fc) * RW'(t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s11 <= 1'b0;
		else if (adv)
			vld_s11 <= dt_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s11.last <= dt_p.last;
			r_s11.pa   <= dt_p.zero ? CW'(0) : pa[RW-1:Q];
			r_s11.pb   <= dt_p.zero ? CW'(0) : pb[RW-1:Q];
		end
	end

	assign res_vld = vld_s11;
	assign res     = r_s11;

endmodule

/* design/blti_accum.sv */
// Per-texel accumulator and output register of the BRDF LUT texel integrator.
// Depends on blti_pkg. Also produces the pipeline advance enable.
module blti_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  blti_pkg::samp_res_t           in_res,
	output logic                          adv,
	output logic                          out_vld,
	input  logic                          out_rdy,
	output logic [blti_pkg::OUT_W-1:0]    scale,
	output logic [blti_pkg::OUT_W-1:0]    bias
);

	localparam int AW = blti_pkg::ACC_W;
	localparam int CW = blti_pkg::C_W;
	localparam int OW = blti_pkg::OUT_W;

	logic [AW-1:0] sum_a_q, sum_b_q;
	logic [AW-1:0] nxt_a, nxt_b;
	logic [CW-1:0] avg_a, avg_b;
	logic          out_vld_q;
	logic [OW-1:0] scale_q, bias_q;
	logic          fin;

	assign nxt_a = sum_a_q + AW'(in_res.pa);
	assign nxt_b = sum_b_q + AW'(in_res.pb);
	assign avg_a = nxt_a[AW-1:blti_pkg::SMP_W];
	assign avg_b = nxt_b[AW-1:blti_pkg::SMP_W];

	// only the last sample of a texel needs the output slot
	assign adv = !(in_vld && in_res.last && out_vld_q && !out_rdy);
	assign fin = adv && in_vld && in_res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q   <= '0;
			sum_b_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv && in_vld) begin
				sum_a_q <= in_res.last ? AW'(0) : nxt_a;
				sum_b_q <= in_res.last ? AW'(0) : nxt_b;
			end
			if (fin)
				out_vld_q <= 1'b1;
			else if (out_rdy)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			scale_q <= (avg_a > CW'(blti_pkg::OUT_MAX)) ? blti_pkg::OUT_MAX : avg_a[OW-1:0];
			bias_q  <= (avg_b > CW'(blti_pkg::OUT_MAX)) ? blti_pkg::OUT_MAX : avg_b[OW-1:0];
		end
	end

	assign out_vld = out_vld_q;
	assign scale   = scale_q;
	assign bias    = bias_q;

endmodule

/* test/brdf_lut_texel_integrator_checker.sv */
// Checker for the BRDF LUT texel integrator: watches the texel, result and
// register channels, predicts (A, B) per texel and counts mismatches. Uses blti_pkg.
module brdf_lut_texel_integrator_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	import blti_pkg::*;

	typedef longint unsigned u64_t;
	typedef struct packed {
		logic [17:0] scale_term;
		logic [17:0] bias_term;
	} ab_pair_t;

	localparam u64_t Q1 = u64_t'(1) << FRAC_BITS;

	logic [12:0] width_reg, height_reg;
	ab_pair_t    ab_queue[$];
	longint      cos_tab[SAMPLES];

	function automatic u64_t root_floor(u64_t v);
		u64_t r, b;
		r = 0;
		b = u64_t'(1) << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic u64_t times30(u64_t a, u64_t b);
		return (a * b) >> 30;
	endfunction

	function automatic u64_t taylor_sine(u64_t t);
		u64_t t2, v;
		t2 = times30(t, t);
		v = (u64_t'(1) << 30) - t2 / 110;
		v = (u64_t'(1) << 30) - times30(t2, v) / 72;
		v = (u64_t'(1) << 30) - times30(t2, v) / 42;
		v = (u64_t'(1) << 30) - times30(t2, v) / 20;
		v = (u64_t'(1) << 30) - times30(t2, v) / 6;
		return times30(t, v);
	endfunction

	function automatic longint to_q(u64_t v);
		u64_t r;
		r = (v + (u64_t'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		return (r > Q1) ? longint'(Q1) : longint'(r);
	endfunction

	function automatic u64_t texel_coord(u64_t idx, logic [12:0] n);
		u64_t d, v;
		d = (n == 0) ? 1 : n;
		v = ((2 * idx + 1) << FRAC_BITS) / (2 * d);
		return (v > Q1) ? Q1 : v;
	endfunction

	function automatic u64_t out_fmt(u64_t v);
		v >>= (FRAC_BITS - 16);
		return (v > 262143) ? 262143 : v;
	endfunction

	function automatic ab_pair_t integrate_texel(logic [11:0] col, logic [11:0] row);
		u64_t nv, rough, a, a2, vx, eps, sa, sb, xi, den, ratio, ct, st;
		u64_t vh, g, om, p2, p4, fc, t;
		longint hx, dotp;
		logic [31:0] rev;
		ab_pair_t r;
		nv = texel_coord(col, width_reg);
		rough = texel_coord(row, height_reg);
		a = (rough * rough) >> FRAC_BITS;
		a2 = (a * a) >> FRAC_BITS;
		vx = root_floor((Q1 - ((nv * nv) >> FRAC_BITS)) << FRAC_BITS);
		eps = (Q1 + 50000) / 100000;
		if (eps == 0)
			eps = 1;
		sa = 0;
		sb = 0;
		for (int i = 0; i < SAMPLES; i++) begin
			rev = {<<{32'(i)}};
			xi = u64_t'(rev) >> (32 - FRAC_BITS);
			den = Q1 - (((Q1 - a2) * xi) >> FRAC_BITS);
			if (den == 0)
				ratio = Q1;
			else begin
				ratio = ((Q1 - xi) << FRAC_BITS) / den;
				if (ratio > Q1)
					ratio = Q1;
			end
			ct = root_floor(ratio << FRAC_BITS);
			if (ct > Q1)
				ct = Q1;
			st = root_floor((Q1 - ((ct * ct) >> FRAC_BITS)) << FRAC_BITS);
			hx = (cos_tab[i] * longint'(st)) / longint'(Q1);
			dotp = longint'(vx) * hx + longint'(nv) * longint'(ct);
			if (dotp <= 0)
				continue;
			vh = u64_t'(dotp) >> FRAC_BITS;
			if (vh > Q1)
				vh = Q1;
			if (vh == 0)
				continue;
			g = (nv * vh) / (((vh * ct) >> FRAC_BITS) + eps);
			if (g > (u64_t'(256) << FRAC_BITS))
				g = u64_t'(256) << FRAC_BITS;
			om = Q1 - vh;
			p2 = (om * om) >> FRAC_BITS;
			p4 = (p2 * p2) >> FRAC_BITS;
			fc = (p4 * om) >> FRAC_BITS;
			t = (g * vh) / (((ct * nv) >> FRAC_BITS) + eps);
			if (t > (u64_t'(1024) << FRAC_BITS))
				t = u64_t'(1024) << FRAC_BITS;
			sa += ((Q1 - fc) * t) >> FRAC_BITS;
			sb += (fc * t) >> FRAC_BITS;
		end
		r.scale_term = 18'(out_fmt(sa / SAMPLES));
		r.bias_term = 18'(out_fmt(sb / SAMPLES));
		return r;
	endfunction

	initial begin
		u64_t k, quad, t;
		longint sv, cv;
		for (int i = 0; i < SAMPLES; i++) begin
			k = u64_t'(i) * 4;
			quad = (k / SAMPLES) & 3;
			t = (k % SAMPLES) * 64'd1686629713 / SAMPLES;
			sv = to_q(taylor_sine(t));
			cv = to_q(taylor_sine(64'd1686629713 - t));
			case (quad)
				0: cos_tab[i] = cv;
				1: cos_tab[i] = -sv;
				2: cos_tab[i] = -cv;
				default: cos_tab[i] = sv;
			endcase
		end
	end

	assign pending = ab_queue.size();

	always @(posedge clk or negedge arst_n) begin
		ab_pair_t want, got;
		if (!arst_n) begin
			width_reg <= 13'd512;
			height_reg <= 13'd512;
			fail_count <= 0;
			results_seen <= 0;
			ab_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LUT_WIDTH)
					width_reg <= cfg_data;
				else
					height_reg <= cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready)
				ab_queue.push_back(integrate_texel(s_axis_tdata[11:0], s_axis_tdata[23:12]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.scale_term = m_axis_tdata[17:0];
				got.bias_term = m_axis_tdata[35:18];
				results_seen <= results_seen + 1;
				if (ab_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result scale=%0d bias=%0d",
							got.scale_term, got.bias_term);
					fail_count <= fail_count + 1;
				end else begin
					want = ab_queue.pop_front();
					if (want != got || m_axis_tdata[39:36] != 0) begin
						if (fail_count < 10)
							$display("mismatch: scale exp %0d got %0d, bias exp %0d got %0d",
								want.scale_term, got.scale_term,
								want.bias_term, got.bias_term);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* test/tb_brdf_lut_texel_integrator.sv */
// Testbench top for the BRDF LUT texel integrator: clock, reset, texel stimulus,
// register phases and verdict. Depends on blti_pkg and the checker module.
module tb_brdf_lut_texel_integrator;
	import blti_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [11:0] col_index, [23:12] row_index
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [17:0] scale_term, [35:18] bias_term
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [12:0] cfg_data;
	int          fail_count, pending, results_seen;
	int          idle_cycles;
	bit          calm;           // no idling in the final stretch
	bit          hold_sink;      // long receiver hold-off
	int          texels_sent;

	brdf_lut_texel_integrator dut (.*);

	brdf_lut_texel_integrator_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: random stall bursts, a long hold-off on request
	initial begin
		int burst;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 0;
				for (int i = 0; i < 2000; i++)
					@(posedge clk);
				hold_sink = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 13);
				m_axis_tready <= 0;
				repeat (burst) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// watchdog: ends the run with a failure when texel and result transactions stop
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("watchdog expired");
			$display("== FAIL ==");
			$finish;
		end
	end

	// tvalid stays high after a transaction; a random gap before the next one or the caller drops it
	task automatic send_texel(logic [11:0] col, logic [11:0] row);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {row, col};
		do
			@(posedge clk);
		while (!s_axis_tready);
		texels_sent++;
	endtask

	task automatic write_size(reg_idx_t idx, logic [12:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_empty;
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic drain;
		wait_empty();
		repeat (300) @(posedge clk);
	endtask

	// random texel mostly inside the table, sometimes beyond it
	task automatic random_texel(int w, int h);
		logic [11:0] c, r;
		c = ($urandom_range(0, 7) == 0 || w == 0) ? 12'($urandom) :
			12'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
		r = ($urandom_range(0, 7) == 0 || h == 0) ? 12'($urandom) :
			12'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
		send_texel(c, r);
	endtask

	initial begin
		int w, h;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		cfg_valid = 0;
		cfg_index = REG_LUT_WIDTH;
		cfg_data = 0;
		calm = 0;
		hold_sink = 0;
		texels_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset sizes, corners, and indices beyond the table
		send_texel(0, 0);
		send_texel(511, 511);
		send_texel(0, 511);
		send_texel(511, 0);
		send_texel(12'hFFF, 12'hFFF);
		send_texel(600, 5);
		send_texel(12'hAAA, 12'h555);
		send_texel(12'h555, 12'hAAA);
		drain();
		// zero size counts as one; single-texel and widest tables
		write_size(REG_LUT_WIDTH, 13'd0);
		write_size(REG_LUT_HEIGHT, 13'd1);
		send_texel(0, 0);
		send_texel(1, 12'hFFF);
		drain();
		write_size(REG_LUT_WIDTH, 13'd4096);
		write_size(REG_LUT_HEIGHT, 13'h1FFF);
		send_texel(0, 0);
		send_texel(4095, 4095);
		send_texel(2048, 0);
		drain();
		write_size(REG_LUT_WIDTH, 13'h1FFF);
		write_size(REG_LUT_HEIGHT, 13'd0);
		send_texel(12'hFFF, 0);
		send_texel(0, 12'hFFF);
		drain();

		// random phases with varied sizes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin w = 1; h = 4096; end
				1: begin w = 4096; h = 1; end
				2: begin w = 32; h = 32; end
				default: begin
					w = $urandom_range(1, 4096);
					h = $urandom_range(1, 4096);
				end
			endcase
			write_size(REG_LUT_WIDTH, 13'(w));
			write_size(REG_LUT_HEIGHT, 13'(h));
			if (ph == 3)
				hold_sink = 1;     // results back up, input stalls
			if (ph == 7)
				calm = 1;
			for (int n = 0; n < 140; n++) begin
				random_texel(w, h);
				if (n == 70 && ph == 5)
					wait_empty();
			end
			drain();
		end

		$display("covered %0d texels, %0d results, sizes from 0 to 8191 incl. out-of-range",
			texels_sent, results_seen);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
